// ===== rtl/cls_pkg.sv =====
// ----------------------------------------------------------------------------
// cls_pkg
// types, register indexes, step and status codes shared by the clamp
// lock sequencer files
// ----------------------------------------------------------------------------
package cls_pkg;

  localparam int CFG_W  = 12;
  localparam int ADDR_W = 4;
  localparam int TICK_W = 13;
  localparam int STEP_W = 3;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_UNLOCK_DELAY  = 4'd0;
  localparam logic [ADDR_W-1:0] REG_CLOSE_TIMEOUT = 4'd1;
  localparam logic [ADDR_W-1:0] REG_CLOSE_SETTLE  = 4'd2;
  localparam logic [ADDR_W-1:0] REG_OPEN_SETTLE   = 4'd3;

  // register reset values
  localparam logic [CFG_W-1:0] UNLOCK_DELAY_RST  = 12'd20;
  localparam logic [CFG_W-1:0] CLOSE_TIMEOUT_RST = 12'd250;
  localparam logic [CFG_W-1:0] CLOSE_SETTLE_RST  = 12'd20;
  localparam logic [CFG_W-1:0] OPEN_SETTLE_RST   = 12'd40;

  // sequencer steps
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_UNLOCK = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MOVE   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SETTLE = 3'd4;

  // status codes
  localparam logic [1:0] ST_RUNNING   = 2'd0;
  localparam logic [1:0] ST_CLOSE_OK  = 2'd1;
  localparam logic [1:0] ST_CLOSE_BAD = 2'd2;
  localparam logic [1:0] ST_OPEN_OK   = 2'd3;

  typedef struct packed {
    logic want_closed;
    logic sensor_closed;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       servo_unlocked;
    logic       valve_on;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CFG_W-1:0]  wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [CFG_W-1:0] unlock_delay;
    logic [CFG_W-1:0] close_timeout;
    logic [CFG_W-1:0] close_settle;
    logic [CFG_W-1:0] open_settle;
  } cfg_t;

endpackage

// ===== rtl/cls_chan_if.sv =====
// ----------------------------------------------------------------------------
// cls_chan_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface cls_chan_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/cls_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cls_cfg_regs
// timing registers of the clamp lock sequencer, written over the config
// channel; writes to unknown indexes are dropped
// ----------------------------------------------------------------------------
module cls_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  cls_chan_if.sink     cfg,
  output cls_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.unlock_delay  <= cls_pkg::UNLOCK_DELAY_RST;
      regs.close_timeout <= cls_pkg::CLOSE_TIMEOUT_RST;
      regs.close_settle  <= cls_pkg::CLOSE_SETTLE_RST;
      regs.open_settle   <= cls_pkg::OPEN_SETTLE_RST;
    end else if (cfg.valid) begin
      case (cfg.data.addr)
        cls_pkg::REG_UNLOCK_DELAY:  regs.unlock_delay  <= cfg.data.wdata;
        cls_pkg::REG_CLOSE_TIMEOUT: regs.close_timeout <= cfg.data.wdata;
        cls_pkg::REG_CLOSE_SETTLE:  regs.close_settle  <= cfg.data.wdata;
        cls_pkg::REG_OPEN_SETTLE:   regs.open_settle   <= cfg.data.wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/clamp_lock_sequencer.sv =====
// ----------------------------------------------------------------------------
// clamp_lock_sequencer
// pneumatic clamp sequencer with servo lock, one control tick per transfer
// result path: the input transfer lands in the input register, then the state
//   update writes the result register
// throughput: one tick per cycle while the result sink does not stall
// reset: synchronous rst clears state to idle, open, servo locked, valve off,
//   and loads the timing registers with their defaults
// ----------------------------------------------------------------------------
module clamp_lock_sequencer (
  input  logic       clk,
  input  logic       rst,
  cls_chan_if.sink   in_ch,
  cls_chan_if.source out_ch,
  cls_chan_if.sink   cfg
);

  cls_pkg::cfg_t regs;

  cls_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input register
  logic         s1_valid;
  cls_pkg::in_t s1_data;
  logic         advance;

  // sequencer state
  logic                        latched_dir, latched_dir_next;
  logic [cls_pkg::STEP_W-1:0]  step, step_next;
  logic [cls_pkg::TICK_W-1:0]  tick_count, tick_count_next;
  logic [1:0]                  pending_status, pending_status_next;
  logic [1:0]                  shown_status, shown_status_next;
  logic                        servo_level, servo_level_next;
  logic                        valve_level, valve_level_next;

  // result register
  logic          out_valid;
  cls_pkg::out_t out_data;

  logic                       dir;
  logic [cls_pkg::CFG_W-1:0]  limit;
  logic [cls_pkg::TICK_W-1:0] tc_inc;
  logic                       wait_over;
  logic                       unlock_set;

  assign advance      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || advance;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data <= in_ch.data;
    end
  end

  // next-state logic
  always_comb begin
    dir = (step == cls_pkg::STEP_IDLE) ? s1_data.want_closed : latched_dir;

    case (step)
      cls_pkg::STEP_UNLOCK: limit = regs.unlock_delay;
      cls_pkg::STEP_WAIT:   limit = dir ? regs.close_timeout : regs.open_settle;
      cls_pkg::STEP_SETTLE: limit = regs.close_settle;
      default:              limit = regs.unlock_delay;
    endcase

    tc_inc     = tick_count + 13'd1;
    wait_over  = tc_inc > {1'b0, limit};
    unlock_set = (!wait_over && tc_inc == 13'd1) ||
                 (wait_over && regs.unlock_delay == '0);

    latched_dir_next    = dir;
    step_next           = step;
    tick_count_next     = tick_count;
    pending_status_next = pending_status;
    shown_status_next   = shown_status;
    servo_level_next    = servo_level;
    valve_level_next    = valve_level;

    if (dir) begin
      case (step)
        cls_pkg::STEP_IDLE: begin
          if (s1_data.sensor_closed) begin
            shown_status_next = cls_pkg::ST_CLOSE_OK;
          end else begin
            shown_status_next = cls_pkg::ST_RUNNING;
            tick_count_next   = '0;
            step_next         = cls_pkg::STEP_UNLOCK;
          end
        end
        cls_pkg::STEP_UNLOCK: begin
          tick_count_next = wait_over ? '0 : tc_inc;
          if (unlock_set) servo_level_next = 1'b1;
          if (wait_over) step_next = cls_pkg::STEP_MOVE;
        end
        cls_pkg::STEP_MOVE: begin
          valve_level_next = 1'b1;
          step_next        = cls_pkg::STEP_WAIT;
        end
        cls_pkg::STEP_WAIT: begin
          if (s1_data.sensor_closed) begin
            tick_count_next     = '0;
            pending_status_next = cls_pkg::ST_CLOSE_OK;
            step_next           = cls_pkg::STEP_SETTLE;
          end else begin
            tick_count_next = wait_over ? '0 : tc_inc;
            if (wait_over) begin
              valve_level_next    = 1'b0;
              pending_status_next = cls_pkg::ST_CLOSE_BAD;
              step_next           = cls_pkg::STEP_SETTLE;
            end
          end
        end
        cls_pkg::STEP_SETTLE: begin
          tick_count_next = wait_over ? '0 : tc_inc;
          if (wait_over) begin
            servo_level_next  = 1'b0;
            step_next         = cls_pkg::STEP_IDLE;
            shown_status_next = pending_status;
          end
        end
        default: step_next = cls_pkg::STEP_IDLE;
      endcase
    end else begin
      case (step)
        cls_pkg::STEP_IDLE: begin
          if (!s1_data.sensor_closed) begin
            servo_level_next  = 1'b0;
            shown_status_next = cls_pkg::ST_OPEN_OK;
          end else begin
            shown_status_next = cls_pkg::ST_RUNNING;
            tick_count_next   = '0;
            step_next         = cls_pkg::STEP_UNLOCK;
          end
        end
        cls_pkg::STEP_UNLOCK: begin
          tick_count_next = wait_over ? '0 : tc_inc;
          if (unlock_set) servo_level_next = 1'b1;
          if (wait_over) step_next = cls_pkg::STEP_MOVE;
        end
        cls_pkg::STEP_MOVE: begin
          valve_level_next = 1'b0;
          step_next        = cls_pkg::STEP_WAIT;
        end
        cls_pkg::STEP_WAIT: begin
          tick_count_next = wait_over ? '0 : tc_inc;
          if (wait_over) begin
            servo_level_next  = 1'b0;
            step_next         = cls_pkg::STEP_IDLE;
            shown_status_next = cls_pkg::ST_OPEN_OK;
          end
        end
        default: step_next = cls_pkg::STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_dir    <= 1'b0;
      step           <= cls_pkg::STEP_IDLE;
      tick_count     <= '0;
      pending_status <= cls_pkg::ST_RUNNING;
      shown_status   <= cls_pkg::ST_RUNNING;
      servo_level    <= 1'b0;
      valve_level    <= 1'b0;
    end else if (advance) begin
      latched_dir    <= latched_dir_next;
      step           <= step_next;
      tick_count     <= tick_count_next;
      pending_status <= pending_status_next;
      shown_status   <= shown_status_next;
      servo_level    <= servo_level_next;
      valve_level    <= valve_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.status         <= shown_status_next;
      out_data.servo_unlocked <= servo_level_next;
      out_data.valve_on       <= valve_level_next;
    end
  end

  // checks
  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    step == cls_pkg::STEP_IDLE |-> tick_count == '0)
    else $error("tick count not clear while idle");

  a_status_only_idle: assert property (@(posedge clk) disable iff (rst)
    shown_status != cls_pkg::ST_RUNNING |-> step == cls_pkg::STEP_IDLE)
    else $error("final status shown while sequence running");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= cls_pkg::STEP_SETTLE)
    else $error("step left its range");

  a_in_captured: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> s1_valid)
    else $error("input transfer not held in input register");

endmodule

// ===== test/clamp_lock_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// clamp_lock_sequencer_tb
// drives control ticks through the clamp lock sequencer with bursty input
// and a stalling result sink, predicts every tick's status, servo and valve
// levels in step with the timing registers, and checks each result in order
// ----------------------------------------------------------------------------
module clamp_lock_sequencer_tb;

  localparam int PIPE_LAT     = 2;
  localparam int SENSOR_HOLDS = 1 << 30;
  localparam int RANDOM_TICKS = 800;
  localparam int CW           = cls_pkg::CFG_W;
  localparam int AW           = cls_pkg::ADDR_W;

  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PULSE} sink_mode_t;

  logic clk;
  logic rst;

  cls_chan_if #(.payload_t(cls_pkg::in_t))     tick_if ();
  cls_chan_if #(.payload_t(cls_pkg::out_t))    result_if ();
  cls_chan_if #(.payload_t(cls_pkg::cfg_wr_t)) cfg_if ();

  clamp_lock_sequencer DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (tick_if),
    .out_ch (result_if),
    .cfg    (cfg_if)
  );

  // predicted sequencer state
  cls_pkg::cfg_t              timing;
  logic                       dir_q;
  logic [cls_pkg::STEP_W-1:0] seq_step;
  logic [cls_pkg::TICK_W-1:0] ticks;
  logic [1:0]                 held_status;
  logic [1:0]                 status_q;
  logic                       servo_q;
  logic                       valve_q;

  cls_pkg::out_t pending_results[$];
  int   mismatch_count = 0;
  int   results_seen = 0;
  int   ticks_sent = 0;
  int   burst_left = 0;
  bit   steady_feed = 1'b0;
  bit   long_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("clamp_lock_sequencer_tb NOT OK");
    $finish;
  end

  function automatic bit tick_wait_over(input logic [CW-1:0] span);
    ticks = ticks + 1'b1;
    if (ticks > span) begin
      ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic cls_pkg::out_t clamp_tick(input cls_pkg::in_t t);
    bit            over;
    cls_pkg::out_t r;
    if (seq_step == cls_pkg::STEP_IDLE) dir_q = t.want_closed;
    case (seq_step)
      cls_pkg::STEP_IDLE: begin
        if (dir_q == t.sensor_closed) begin
          // already where it was asked to be
          if (!dir_q) servo_q = 1'b0;
          status_q = dir_q ? cls_pkg::ST_CLOSE_OK : cls_pkg::ST_OPEN_OK;
        end else begin
          status_q = cls_pkg::ST_RUNNING;
          ticks = '0;
          seq_step = cls_pkg::STEP_UNLOCK;
        end
      end
      cls_pkg::STEP_UNLOCK: begin
        over = tick_wait_over(timing.unlock_delay);
        if (ticks == 1 || (over && timing.unlock_delay == '0)) servo_q = 1'b1;
        if (over) seq_step = cls_pkg::STEP_MOVE;
      end
      cls_pkg::STEP_MOVE: begin
        valve_q = dir_q;
        seq_step = cls_pkg::STEP_WAIT;
      end
      cls_pkg::STEP_WAIT: begin
        if (dir_q) begin
          if (t.sensor_closed) begin
            ticks = '0;
            held_status = cls_pkg::ST_CLOSE_OK;
            seq_step = cls_pkg::STEP_SETTLE;
          end else if (tick_wait_over(timing.close_timeout)) begin
            valve_q = 1'b0;
            held_status = cls_pkg::ST_CLOSE_BAD;
            seq_step = cls_pkg::STEP_SETTLE;
          end
        end else if (tick_wait_over(timing.open_settle)) begin
          servo_q = 1'b0;
          seq_step = cls_pkg::STEP_IDLE;
          status_q = cls_pkg::ST_OPEN_OK;
        end
      end
      cls_pkg::STEP_SETTLE: begin
        if (!dir_q) begin
          seq_step = cls_pkg::STEP_IDLE;
        end else if (tick_wait_over(timing.close_settle)) begin
          servo_q = 1'b0;
          seq_step = cls_pkg::STEP_IDLE;
          status_q = held_status;
        end
      end
      default: seq_step = cls_pkg::STEP_IDLE;
    endcase
    r.status = status_q;
    r.servo_unlocked = servo_q;
    r.valve_on = valve_q;
    return r;
  endfunction

  task automatic send_tick(input cls_pkg::in_t t);
    int gap;
    if (!steady_feed && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        tick_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    tick_if.valid <= 1'b1;
    tick_if.data <= t;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    pending_results.push_back(clamp_tick(t));
  endtask

  task automatic settle_results();
    tick_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // leaves valid high so back-to-back writes run without valid dropping between them
  task automatic write_timing(input logic [AW-1:0] idx, input logic [CW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{addr: idx, wdata: val};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      cls_pkg::REG_UNLOCK_DELAY:  timing.unlock_delay = val;
      cls_pkg::REG_CLOSE_TIMEOUT: timing.close_timeout = val;
      cls_pkg::REG_CLOSE_SETTLE:  timing.close_settle = val;
      cls_pkg::REG_OPEN_SETTLE:   timing.open_settle = val;
      default: ;
    endcase
  endtask

  task automatic load_timing(input logic [CW-1:0] unlock, input logic [CW-1:0] timeout,
                             input logic [CW-1:0] csettle, input logic [CW-1:0] osettle);
    logic [AW-1:0] junk_idx;
    settle_results();
    junk_idx = cls_pkg::REG_OPEN_SETTLE + AW'($urandom_range(1, 12));
    write_timing(cls_pkg::REG_UNLOCK_DELAY, unlock);
    write_timing(cls_pkg::REG_CLOSE_TIMEOUT, timeout);
    write_timing(cls_pkg::REG_CLOSE_SETTLE, csettle);
    write_timing(cls_pkg::REG_OPEN_SETTLE, osettle);
    // index past the register file must be dropped
    write_timing(junk_idx, CW'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [CW-1:0] pick_span();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CW'(1);
      2, 3, 4: return CW'($urandom_range(2, 6));
      5, 6:    return CW'($urandom_range(7, 20));
      default: return CW'($urandom_range(21, 60));
    endcase
  endfunction

  // one request from idle back to idle; sensor toggles once at flip_at
  task automatic run_clamp_cycle(input bit want, input bit sensor_start, input int flip_at,
                                 input bit jitter_want);
    int           n;
    cls_pkg::in_t t;
    n = 0;
    do begin
      t.want_closed = (jitter_want && n > 0) ? 1'($urandom_range(0, 1)) : want;
      t.sensor_closed = sensor_start ^ (n >= flip_at);
      send_tick(t);
      n++;
    end while (seq_step != cls_pkg::STEP_IDLE);
    ticks_sent += n;
  endtask

  task automatic random_episode();
    bit want;
    bit start;
    int reach;
    int flip_at;
    want = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      run_clamp_cycle(want, 1'($urandom_range(0, 1)), $urandom_range(0, 3), 1'b1);
    end else begin
      start = ($urandom_range(0, 4) == 0) ? want : ~want;
      reach = int'(timing.unlock_delay) + int'(timing.close_timeout) + 4;
      flip_at = ($urandom_range(0, 4) == 0) ? SENSOR_HOLDS : $urandom_range(0, reach);
      run_clamp_cycle(want, start, flip_at, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_reset_timing();
    run_clamp_cycle(1'b1, 1'b0, 40, 1'b0);
    run_clamp_cycle(1'b0, 1'b1, 0, 1'b0);
    run_clamp_cycle(1'b1, 1'b0, SENSOR_HOLDS, 1'b0);
    run_clamp_cycle(1'b0, 1'b1, SENSOR_HOLDS, 1'b0);
  endtask

  task automatic test_zero_waits();
    load_timing('0, '0, '0, '0);
    run_clamp_cycle(1'b1, 1'b0, 3, 1'b0);
    run_clamp_cycle(1'b1, 1'b1, SENSOR_HOLDS, 1'b0);
    run_clamp_cycle(1'b0, 1'b1, SENSOR_HOLDS, 1'b0);
    run_clamp_cycle(1'b0, 1'b0, SENSOR_HOLDS, 1'b0);
    run_clamp_cycle(1'b1, 1'b0, SENSOR_HOLDS, 1'b1);
    run_clamp_cycle(1'b0, 1'b0, SENSOR_HOLDS, 1'b0);
    run_clamp_cycle(1'b0, 1'b1, 2, 1'b1);
  endtask

  // widest timeout, sensor closes well before it runs out
  task automatic test_longest_waits();
    load_timing(CW'(60), '1, CW'(60), CW'(60));
    run_clamp_cycle(1'b1, 1'b0, 100, 1'b0);
    run_clamp_cycle(1'b0, 1'b1, SENSOR_HOLDS, 1'b0);
  endtask

  task automatic test_backpressure();
    int start;
    load_timing(CW'(2), CW'(5), CW'(3), CW'(4));
    start = ticks_sent;
    steady_feed = 1'b1;
    long_hold_req = 1'b1;
    while (ticks_sent - start < 100) random_episode();
    steady_feed = 1'b0;
  endtask

  task automatic test_random_sequences();
    int start;
    int phase_start;
    start = ticks_sent;
    while (ticks_sent - start < RANDOM_TICKS) begin
      load_timing(pick_span(), pick_span(), pick_span(), pick_span());
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < 150) random_episode();
    end
  endtask

  // result sink with its own stall pattern and an on-demand long hold
  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    int         hold_left;
    mode = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:  result_if.ready <= 1'b1;
          SINK_LIGHT: result_if.ready <= ($urandom_range(0, 4) != 0);
          SINK_HEAVY: result_if.ready <= ($urandom_range(0, 2) == 0);
          default:    result_if.ready <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    cls_pkg::out_t exp_r;
    if (!rst && result_if.valid && result_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d with no tick outstanding: status %0d servo %0b valve %0b",
                   results_seen, result_if.data.status, result_if.data.servo_unlocked,
                   result_if.data.valve_on);
      end else begin
        exp_r = pending_results.pop_front();
        if (result_if.data.status !== exp_r.status ||
            result_if.data.servo_unlocked !== exp_r.servo_unlocked ||
            result_if.data.valve_on !== exp_r.valve_on) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected status %0d servo %0b valve %0b, got %0d %0b %0b",
                     results_seen, exp_r.status, exp_r.servo_unlocked, exp_r.valve_on,
                     result_if.data.status, result_if.data.servo_unlocked,
                     result_if.data.valve_on);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    tick_if.valid = 1'b0;
    tick_if.data = '0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    timing = '{cls_pkg::UNLOCK_DELAY_RST, cls_pkg::CLOSE_TIMEOUT_RST,
               cls_pkg::CLOSE_SETTLE_RST, cls_pkg::OPEN_SETTLE_RST};
    dir_q = 1'b0;
    seq_step = cls_pkg::STEP_IDLE;
    ticks = '0;
    held_status = cls_pkg::ST_RUNNING;
    status_q = cls_pkg::ST_RUNNING;
    servo_q = 1'b0;
    valve_q = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_timing();
    test_zero_waits();
    test_longest_waits();
    test_backpressure();
    test_random_sequences();

    settle_results();
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("clamp_lock_sequencer_tb OK");
    else
      $display("clamp_lock_sequencer_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cls_pkg.sv
rtl/cls_chan_if.sv
rtl/cls_cfg_regs.sv
rtl/clamp_lock_sequencer.sv
test/clamp_lock_sequencer_tb.sv
